// ===== hdl/asp_pkg.sv =====
package asp_pkg;

    localparam int ITER   = 20;
    localparam int CW     = 16;
    localparam int FRAC   = 16;
    localparam int XW     = 36;
    localparam int ZW     = 26;
    localparam int CSW    = 20;
    localparam int RW     = 36;
    localparam int QW     = 10;
    localparam int SW     = 9;
    localparam int HW     = RW - FRAC + CSW;
    localparam int LW     = FRAC + CSW;
    localparam int MW     = 25;
    localparam int OW     = 27;
    localparam int QDEPTH = 4;
    localparam int QPW    = 2;

    localparam logic [15:0]          INV_GAIN   = 16'd39797;
    localparam logic [SW-1:0]        SNAP_RESET = 9'd45;
    localparam logic signed [ZW-1:0] HALF_TURN  = 26'sd11796480;
    localparam logic signed [ZW-1:0] FULL_TURN  = 26'sd23592960;
    localparam logic signed [OW-1:0] SAT_HI     = OW'((2 ** (CW - 1)) - 1);
    localparam logic signed [OW-1:0] SAT_LO     = -SAT_HI - OW'(1);

    typedef struct packed {
        logic signed [CW-1:0] ax;
        logic signed [CW-1:0] ay;
        logic signed [CW-1:0] px;
        logic signed [CW-1:0] py;
        logic                 zero;
        logic [SW-1:0]        step;
    } side_t;

    typedef struct packed {
        side_t                side;
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
    } vec_item_t;

    // atan(2^-i) in degrees, 16 fractional bits
    function automatic logic signed [ZW-1:0] atan_deg(input int i);
        logic signed [ZW-1:0] v;
        case (i)
            0:       v = 26'sd2949120;
            1:       v = 26'sd1740967;
            2:       v = 26'sd919879;
            3:       v = 26'sd466945;
            4:       v = 26'sd234379;
            5:       v = 26'sd117304;
            6:       v = 26'sd58666;
            7:       v = 26'sd29335;
            8:       v = 26'sd14668;
            9:       v = 26'sd7334;
            10:      v = 26'sd3667;
            11:      v = 26'sd1833;
            12:      v = 26'sd917;
            13:      v = 26'sd458;
            14:      v = 26'sd229;
            15:      v = 26'sd115;
            16:      v = 26'sd57;
            17:      v = 26'sd29;
            18:      v = 26'sd14;
            19:      v = 26'sd7;
            20:      v = 26'sd4;
            21:      v = 26'sd2;
            22:      v = 26'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== hdl/asp_front.sv =====
module asp_front
    import asp_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic [63:0]     s_tdata,
    input  logic [SW-1:0]   step,
    output logic            out_valid,
    input  logic            out_ready,
    output vec_item_t       out_item
);

    logic                 valid_reg;
    vec_item_t            item_reg;
    vec_item_t            item_next;
    logic signed [CW-1:0] ax, ay, px, py;
    logic signed [CW:0]   dx, dy, adx, ady;
    logic                 neg;

    assign ax  = s_tdata[15:0];
    assign ay  = s_tdata[31:16];
    assign px  = s_tdata[47:32];
    assign py  = s_tdata[63:48];
    assign dx  = (CW+1)'(px) - (CW+1)'(ax);
    assign dy  = (CW+1)'(py) - (CW+1)'(ay);
    assign neg = dx[CW];
    // left half plane is folded over, angle starts at 180
    assign adx = neg ? -dx : dx;
    assign ady = neg ? -dy : dy;

    always_comb
    begin
        item_next.side.ax   = ax;
        item_next.side.ay   = ay;
        item_next.side.px   = px;
        item_next.side.py   = py;
        item_next.side.zero = (dx == '0) && (dy == '0);
        item_next.side.step = step;
        item_next.x = {{(XW-CW-1-FRAC){adx[CW]}}, adx, {FRAC{1'b0}}};
        item_next.y = {{(XW-CW-1-FRAC){ady[CW]}}, ady, {FRAC{1'b0}}};
        item_next.z = neg ? HALF_TURN : '0;
    end

    assign s_tready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (s_tready)
            valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
            item_reg <= item_next;
    end

endmodule

// ===== hdl/asp_queue.sv =====
module asp_queue
    import asp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  vec_item_t in_item,
    output logic      out_valid,
    input  logic      out_ready,
    output vec_item_t out_item
);

    vec_item_t        mem_reg [QDEPTH];
    logic [QPW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QPW:0]     cnt_reg;
    logic             push, pop;

    assign in_ready  = cnt_reg != (QPW+1)'(QDEPTH);
    assign out_valid = cnt_reg != '0;
    assign out_item  = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= in_item;
    end

endmodule

// ===== hdl/asp_back.sv =====
module asp_back
    import asp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  vec_item_t   in_item,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata
);

    logic en;

    // vectoring pipe
    logic signed [XW-1:0] vx_reg [0:ITER];
    logic signed [XW-1:0] vy_reg [0:ITER];
    logic signed [ZW-1:0] vz_reg [0:ITER];
    side_t                vs_reg [0:ITER];
    logic                 vv_reg [0:ITER];

    // magnitude multiply and angle wrap
    logic [RW-1:0]        mh_reg;
    logic [31:0]          ml_reg;
    logic signed [ZW-1:0] zw_reg;
    side_t                ms_reg;
    logic                 mv_reg;
    logic signed [XW-1:0] xc;
    logic [RW-1:0]        mh_next;
    logic [31:0]          ml_next;
    logic signed [ZW-1:0] zw_next;

    // quotient of angle by step, one bit per stage
    logic [QW-1:0]        dn_reg [0:QW];
    logic [QW-1:0]        drem_reg [0:QW];
    logic [QW-1:0]        dq_reg [0:QW];
    logic [SW-1:0]        dd_reg [0:QW];
    logic [RW-1:0]        dr_reg [0:QW];
    side_t                ds_reg [0:QW];
    logic                 dv_reg [0:QW];
    logic [SW-1:0]        step_eff;
    logic [ZW:0]          nsum;

    // rotation pipe
    logic signed [CSW-1:0] rc_reg [0:ITER];
    logic signed [CSW-1:0] rs_reg [0:ITER];
    logic signed [ZW-1:0]  rz_reg [0:ITER];
    logic                  rf_reg [0:ITER];
    logic [RW-1:0]         rr_reg [0:ITER];
    side_t                 rsd_reg [0:ITER];
    logic                  rv_reg [0:ITER];
    logic [QW+SW-1:0]      prod;
    logic [SW-1:0]         t_deg;
    logic signed [QW-1:0]  t_sgn;
    logic                  flip;

    // scale multiply
    logic [HW-1:0]   hx_reg, hy_reg;
    logic [LW-1:0]   lx_reg, ly_reg;
    logic            sgx_reg, sgy_reg;
    side_t           ss_reg;
    logic            sv_reg;
    logic [CSW-1:0]  acx, acy;

    // output register
    logic [CW-1:0]         ox_reg, oy_reg;
    logic                  ov_reg;
    logic [CW-1:0]         ox_next, oy_next;
    logic [HW:0]           sumx, sumy;
    logic [MW-1:0]         magx, magy;
    logic signed [OW-1:0]  offx, offy, resx, resy;

    assign en       = !ov_reg || m_tready;
    assign in_ready = en;
    assign m_tvalid = ov_reg;
    assign m_tdata  = {oy_reg, ox_reg};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            vx_reg[0] <= in_item.x;
            vy_reg[0] <= in_item.y;
            vz_reg[0] <= in_item.z;
            vs_reg[0] <= in_item.side;
        end
    end

    for (genvar k = 0; k < ITER; k++)
    begin : g_vec
        logic signed [XW-1:0] xs, ys;
        assign xs = vx_reg[k] >>> k;
        assign ys = vy_reg[k] >>> k;
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (vy_reg[k] > 0)
                begin
                    vx_reg[k+1] <= vx_reg[k] + ys;
                    vy_reg[k+1] <= vy_reg[k] - xs;
                    vz_reg[k+1] <= vz_reg[k] + atan_deg(k);
                end
                else
                begin
                    vx_reg[k+1] <= vx_reg[k] - ys;
                    vy_reg[k+1] <= vy_reg[k] + xs;
                    vz_reg[k+1] <= vz_reg[k] - atan_deg(k);
                end
                vs_reg[k+1] <= vs_reg[k];
            end
        end
    end

    assign xc      = vx_reg[ITER][XW-1] ? '0 : vx_reg[ITER];
    assign mh_next = xc[XW-1:FRAC] * INV_GAIN;
    assign ml_next = xc[FRAC-1:0] * INV_GAIN;

    always_comb
    begin
        zw_next = vz_reg[ITER];
        if (zw_next < 0)
            zw_next = zw_next + FULL_TURN;
        else if (zw_next >= FULL_TURN)
            zw_next = zw_next - FULL_TURN;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mh_reg <= mh_next;
            ml_reg <= ml_next;
            zw_reg <= zw_next;
            ms_reg <= vs_reg[ITER];
        end
    end

    // a step of zero acts as one degree
    assign step_eff = (ms_reg.step == '0) ? SW'(1) : ms_reg.step;
    assign nsum     = (ZW+1)'(unsigned'(zw_reg)) + ((ZW+1)'(step_eff) << (FRAC - 1));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dn_reg[0]   <= nsum[FRAC+QW-1:FRAC];
            drem_reg[0] <= '0;
            dq_reg[0]   <= '0;
            dd_reg[0]   <= step_eff;
            dr_reg[0]   <= mh_reg + RW'(ml_reg[31:FRAC]);
            ds_reg[0]   <= ms_reg;
        end
    end

    for (genvar j = 0; j < QW; j++)
    begin : g_div
        logic [QW-1:0] trial;
        logic          ge;
        logic [QW-1:0] q_next;
        assign trial = {drem_reg[j][QW-2:0], dn_reg[j][QW-1-j]};
        assign ge    = trial >= QW'(dd_reg[j]);
        always_comb
        begin
            q_next = dq_reg[j];
            q_next[QW-1-j] = ge;
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                drem_reg[j+1] <= ge ? trial - QW'(dd_reg[j]) : trial;
                dq_reg[j+1]   <= q_next;
                dn_reg[j+1]   <= dn_reg[j];
                dd_reg[j+1]   <= dd_reg[j];
                dr_reg[j+1]   <= dr_reg[j];
                ds_reg[j+1]   <= ds_reg[j];
            end
        end
    end

    // snapped angle fits below two turns, one subtract wraps it
    assign prod  = dq_reg[QW] * dd_reg[QW];
    assign t_deg = (prod[QW-1:0] >= QW'(360)) ? SW'(prod[QW-1:0] - QW'(360))
                                               : SW'(prod[QW-1:0]);
    assign flip  = (t_deg > SW'(90)) && (t_deg < SW'(270));

    always_comb
    begin
        if (flip)
            t_sgn = $signed({1'b0, t_deg}) - QW'(180);
        else if (t_deg >= SW'(270))
            t_sgn = $signed({1'b0, t_deg}) - QW'(360);
        else
            t_sgn = $signed({1'b0, t_deg});
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rc_reg[0]  <= CSW'(INV_GAIN);
            rs_reg[0]  <= '0;
            rz_reg[0]  <= {t_sgn, {FRAC{1'b0}}};
            rf_reg[0]  <= flip;
            rr_reg[0]  <= dr_reg[QW];
            rsd_reg[0] <= ds_reg[QW];
        end
    end

    for (genvar k = 0; k < ITER; k++)
    begin : g_rot
        logic signed [CSW-1:0] cs, sn;
        assign cs = rc_reg[k] >>> k;
        assign sn = rs_reg[k] >>> k;
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (rz_reg[k] >= 0)
                begin
                    rc_reg[k+1] <= rc_reg[k] - sn;
                    rs_reg[k+1] <= rs_reg[k] + cs;
                    rz_reg[k+1] <= rz_reg[k] - atan_deg(k);
                end
                else
                begin
                    rc_reg[k+1] <= rc_reg[k] + sn;
                    rs_reg[k+1] <= rs_reg[k] - cs;
                    rz_reg[k+1] <= rz_reg[k] + atan_deg(k);
                end
                rf_reg[k+1]  <= rf_reg[k];
                rr_reg[k+1]  <= rr_reg[k];
                rsd_reg[k+1] <= rsd_reg[k];
            end
        end
    end

    assign acx = rc_reg[ITER][CSW-1] ? unsigned'(-rc_reg[ITER]) : unsigned'(rc_reg[ITER]);
    assign acy = rs_reg[ITER][CSW-1] ? unsigned'(-rs_reg[ITER]) : unsigned'(rs_reg[ITER]);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hx_reg  <= rr_reg[ITER][RW-1:FRAC] * acx;
            lx_reg  <= rr_reg[ITER][FRAC-1:0] * acx;
            hy_reg  <= rr_reg[ITER][RW-1:FRAC] * acy;
            ly_reg  <= rr_reg[ITER][FRAC-1:0] * acy;
            sgx_reg <= rc_reg[ITER][CSW-1] ^ rf_reg[ITER];
            sgy_reg <= rs_reg[ITER][CSW-1] ^ rf_reg[ITER];
            ss_reg  <= rsd_reg[ITER];
        end
    end

    // offset truncated toward zero, then added to the anchor
    assign sumx = (HW+1)'(hx_reg) + (HW+1)'(lx_reg >> FRAC);
    assign sumy = (HW+1)'(hy_reg) + (HW+1)'(ly_reg >> FRAC);
    assign magx = sumx[FRAC+MW-1:FRAC];
    assign magy = sumy[FRAC+MW-1:FRAC];
    assign offx = sgx_reg ? -$signed(OW'(magx)) : $signed(OW'(magx));
    assign offy = sgy_reg ? -$signed(OW'(magy)) : $signed(OW'(magy));
    assign resx = OW'(ss_reg.ax) + offx;
    assign resy = OW'(ss_reg.ay) + offy;

    always_comb
    begin
        if (ss_reg.zero)
            ox_next = ss_reg.px;
        else if (resx > SAT_HI)
            ox_next = SAT_HI[CW-1:0];
        else if (resx < SAT_LO)
            ox_next = SAT_LO[CW-1:0];
        else
            ox_next = resx[CW-1:0];
        if (ss_reg.zero)
            oy_next = ss_reg.py;
        else if (resy > SAT_HI)
            oy_next = SAT_HI[CW-1:0];
        else if (resy < SAT_LO)
            oy_next = SAT_LO[CW-1:0];
        else
            oy_next = resy[CW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ox_reg <= ox_next;
            oy_reg <= oy_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= ITER; i++)
            begin
                vv_reg[i] <= 1'b0;
                rv_reg[i] <= 1'b0;
            end
            for (int i = 0; i <= QW; i++)
                dv_reg[i] <= 1'b0;
            mv_reg <= 1'b0;
            sv_reg <= 1'b0;
            ov_reg <= 1'b0;
        end
        else if (en)
        begin
            vv_reg[0] <= in_valid;
            for (int i = 0; i < ITER; i++)
            begin
                vv_reg[i+1] <= vv_reg[i];
                rv_reg[i+1] <= rv_reg[i];
            end
            mv_reg    <= vv_reg[ITER];
            dv_reg[0] <= mv_reg;
            for (int i = 0; i < QW; i++)
                dv_reg[i+1] <= dv_reg[i];
            rv_reg[0] <= dv_reg[QW];
            sv_reg    <= rv_reg[ITER];
            ov_reg    <= sv_reg;
        end
    end

endmodule

// ===== hdl/angle_snap_point.sv =====
// channel   dir  handshake          payload
// s_*       in   s_tvalid/s_tready  s_tdata: anchor_x, anchor_y, point_x, point_y
// m_*       out  m_tvalid/m_tready  m_tdata: snapped_x, snapped_y
// cfg_*     in   cfg_wr_en          cfg_wr_data: snap_degrees
//
// one transaction per cycle sustained while m_tready is held, set by the fully unrolled cordic pipes
// path in order: front register, queue, 20 vectoring stages, 10 divider
// stages, 20 rotation stages and the multiply/saturate stages
// rst_n clears all valid state and sets snap_degrees to 45
// a stalled output freezes the back pipe; the queue and front keep taking input until the queue is full
module angle_snap_point
    import asp_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [63:0]   s_tdata,     // anchor_x, anchor_y, point_x, point_y
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [31:0]   m_tdata,     // snapped_x, snapped_y
    input  logic          cfg_wr_en,
    input  logic [SW-1:0] cfg_wr_data  // snap_degrees
);

    logic [SW-1:0] snap_reg;
    logic          f_valid, f_ready, q_valid, q_ready;
    vec_item_t     f_item, q_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            snap_reg <= SNAP_RESET;
        else if (cfg_wr_en)
            snap_reg <= cfg_wr_data;
    end

    asp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .step      (snap_reg),
        .out_valid (f_valid),
        .out_ready (f_ready),
        .out_item  (f_item)
    );

    asp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_item   (f_item),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_item  (q_item)
    );

    asp_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (q_valid),
        .in_ready (q_ready),
        .in_item  (q_item),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

// ===== hdl/asp_checker.sv =====
module asp_sva
    import asp_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);

    logic [7:0] pend_reg;
    logic       in_acc, out_acc;

    assign in_acc  = s_tvalid && s_tready;
    assign out_acc = m_tvalid && m_tready;

    // transactions taken in but not yet delivered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pend_reg <= '0;
        else if (in_acc && !out_acc)
            pend_reg <= pend_reg + 1'b1;
        else if (out_acc && !in_acc)
            pend_reg <= pend_reg - 1'b1;
    end

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> pend_reg != '0)
        else $error("result with no pending input");

    a_reset: assert property (@(posedge clk)
        !rst_n |-> !m_tvalid)
        else $error("output valid during reset");

endmodule

bind angle_snap_point asp_sva u_asp_sva (.*);

// ===== verif/asp_checker.sv =====
module asp_checker
    import asp_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    input  logic          s_tready,
    input  logic [63:0]   s_tdata,
    input  logic          m_tvalid,
    input  logic          m_tready,
    input  logic [31:0]   m_tdata,
    input  logic          cfg_wr_en,
    input  logic [SW-1:0] cfg_wr_data,
    output int            fail_count,
    output int            pending,
    output int            outputs_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic signed [CW-1:0] sx;
        logic signed [CW-1:0] sy;
    } snapped_t;

    snapped_t snapped_q[$];
    logic [SW-1:0] step_reg;

    localparam longint ATAN_TBL[20] = '{2949120, 1740967, 919879, 466945, 234379,
        117304, 58666, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7};

    function automatic longint shr_floor(longint v, int s);
        return v >>> s;
    endfunction

    function automatic logic signed [CW-1:0] clamp16(longint v);
        if (v > 32767)
            return 16'sd32767;
        if (v < -32768)
            return -16'sd32768;
        return v[15:0];
    endfunction

    function automatic longint mul_trunc(longint r, longint c);
        longint ac;
        longint m;
        ac = c < 0 ? -c : c;
        m = (r * ac) >>> 32;
        return c < 0 ? -m : m;
    endfunction

    function automatic snapped_t snap_point(logic [63:0] d, logic [SW-1:0] stepv);
        snapped_t o;
        longint ax, ay, px, py, dx, dy, x, y, z, r, c, s, st, q, t, xs, ys;
        bit flip;
        ax = $signed(d[15:0]);
        ay = $signed(d[31:16]);
        px = $signed(d[47:32]);
        py = $signed(d[63:48]);
        dx = px - ax;
        dy = py - ay;
        flip = 0;
        if (dx == 0 && dy == 0)
        begin
            o.sx = px[15:0];
            o.sy = py[15:0];
            return o;
        end
        if (dx < 0)
        begin
            x = -dx * 65536; y = -dy * 65536; z = 180 * 65536;
        end
        else
        begin
            x = dx * 65536; y = dy * 65536; z = 0;
        end
        for (int i = 0; i < 20; i++)
        begin
            xs = shr_floor(x, i);
            ys = shr_floor(y, i);
            if (y > 0)
            begin
                x += ys; y -= xs; z += ATAN_TBL[i];
            end
            else
            begin
                x -= ys; y += xs; z -= ATAN_TBL[i];
            end
        end
        if (z < 0)
            z += 360 * 65536;
        if (z >= 360 * 65536)
            z -= 360 * 65536;
        if (x < 0)
            x = 0;
        r = (x >>> 16) * 39797 + (((x & 64'hFFFF) * 39797) >>> 16);
        st = stepv;
        if (st == 0)
            st = 1;
        q = (z + st * 32768) / (st * 65536);
        t = (q * st) % 360;
        if (t > 90 && t < 270)
        begin
            t -= 180;
            flip = 1;
        end
        else if (t >= 270)
            t -= 360;
        c = 39797;
        s = 0;
        z = t * 65536;
        for (int i = 0; i < 20; i++)
        begin
            xs = shr_floor(c, i);
            ys = shr_floor(s, i);
            if (z >= 0)
            begin
                c -= ys; s += xs; z -= ATAN_TBL[i];
            end
            else
            begin
                c += ys; s -= xs; z += ATAN_TBL[i];
            end
        end
        if (flip)
        begin
            c = -c;
            s = -s;
        end
        o.sx = clamp16(ax + mul_trunc(r, c));
        o.sy = clamp16(ay + mul_trunc(r, s));
        return o;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $time);
        fail_count++;
    endtask

    assign pending = snapped_q.size();

    initial
    begin
        fail_count = 0;
        outputs_seen = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        snapped_t e;
        if (!rst_n)
            step_reg <= SNAP_RESET;
        else
        begin
            if (cfg_wr_en)
                step_reg <= cfg_wr_data;
            if (s_tvalid && s_tready)
                snapped_q.push_back(snap_point(s_tdata, step_reg));
            if (m_tvalid && m_tready)
            begin
                outputs_seen++;
                if (snapped_q.size() == 0)
                    report_mismatch("unexpected transaction", 0, 0);
                else
                begin
                    e = snapped_q.pop_front();
                    if ($signed(m_tdata[15:0]) != e.sx)
                        report_mismatch("snapped_x", $signed(m_tdata[15:0]), e.sx);
                    if ($signed(m_tdata[31:16]) != e.sy)
                        report_mismatch("snapped_y", $signed(m_tdata[31:16]), e.sy);
                end
            end
        end
    end
endmodule

// ===== verif/tb.sv =====
module tb;
    import asp_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic          clk;
    logic          rst_n;
    logic          s_tvalid;
    logic          s_tready;
    logic [63:0]   s_tdata;
    logic          m_tvalid;
    logic          m_tready;
    logic [31:0]   m_tdata;
    logic          cfg_wr_en;
    logic [SW-1:0] cfg_wr_data;
    int            fail_count;
    int            pending;
    int            outputs_seen;
    int            send_idle;
    int            recv_stall;
    int            hold_off;
    int            items_sent;

    angle_snap_point u_dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
    );

    asp_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .fail_count(fail_count), .pending(pending), .outputs_seen(outputs_seen)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // receiver: random stalls, plus a long hold-off when requested
    always @(posedge clk)
    begin
        if (hold_off > 0)
        begin
            hold_off <= hold_off - 1;
            m_tready <= 0;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_stall);
    end

    task automatic send_point(logic [63:0] d);
        while ($urandom_range(99) < send_idle)
        begin
            s_tvalid <= 0;
            @(posedge clk);
        end
        s_tvalid <= 1;
        s_tdata <= d;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic end_burst;
        s_tvalid <= 0;
        @(posedge clk);
    endtask

    task automatic drain;
        while (pending != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    task automatic write_step(logic [SW-1:0] v);
        cfg_wr_en <= 1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 0;
        @(posedge clk);
    endtask

    function automatic logic [15:0] rand_coord(int mode);
        case (mode)
            0:       return 16'($urandom());
            1:       return 16'($urandom_range(200)) - 16'd100;
            default: return 16'($urandom_range(4000)) - 16'd2000;
        endcase
    endfunction

    function automatic logic [63:0] rand_item();
        logic [15:0] ax, ay;
        int mode;
        mode = $urandom_range(3);
        ax = rand_coord(mode);
        ay = rand_coord(mode);
        if ($urandom_range(15) == 0)
            return {ay, ax, ay, ax};
        if (mode == 3)
            return {ay + 16'($urandom_range(60)) - 16'd30, ax + 16'($urandom_range(60)) - 16'd30,
                    ay, ax};
        return {rand_coord(mode), rand_coord(mode), ay, ax};
    endfunction

    logic [SW-1:0] steps[8] = '{9'd45, 9'd1, 9'd360, 9'd0, 9'd511, 9'd90, 9'd7, 9'd200};

    initial
    begin
        rst_n = 0;
        s_tvalid = 0;
        s_tdata = '0;
        m_tready = 0;
        cfg_wr_en = 0;
        cfg_wr_data = '0;
        send_idle = 0;
        recv_stall = 0;
        hold_off = 0;
        items_sent = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: extremes, zero offset, axes, saturation
        send_point({16'h0005, 16'h0005, 16'h0005, 16'h0005});
        send_point({16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000});
        send_point({16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF});
        send_point({16'h0000, 16'h7FFF, 16'h0000, 16'h8000});
        send_point({16'h7FFF, 16'h0000, 16'h8000, 16'h0000});
        send_point({16'h0000, 16'h0064, 16'h0000, 16'h0000});
        send_point({16'h0000, 16'hFF9C, 16'h0000, 16'h0000});
        send_point({16'h0064, 16'h0000, 16'h0000, 16'h0000});
        send_point({16'hFF9C, 16'h0000, 16'h0000, 16'h0000});
        send_point({16'h0032, 16'h0064, 16'h0000, 16'h0000});
        send_point({16'h0001, 16'h0001, 16'h0000, 16'h0000});
        send_point({16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000});
        send_point({16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000});
        send_point({16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000});
        end_burst();
        drain();

        for (int ph = 0; ph < 8; ph++)
        begin
            write_step(steps[ph]);
            case (ph % 4)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 74; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 74; end
                default: begin send_idle = 22; recv_stall = 22; end
            endcase
            if (ph == 4)
                hold_off = 300;
            for (int k = 0; k < 236; k++)
                send_point(rand_item());
            end_burst();
            drain();
        end

        $display("sent %0d points over 8 step settings, %0d results checked",
                 items_sent, outputs_seen);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        #3000000;
        $display("TB_ERROR");
        $finish;
    end
endmodule

// ===== angle_snap_point.f =====
hdl/asp_pkg.sv
hdl/asp_front.sv
hdl/asp_queue.sv
hdl/asp_back.sv
hdl/angle_snap_point.sv
hdl/asp_checker.sv
verif/asp_checker.sv
verif/tb.sv
